[rtl/core/assert_macros.svh]
// Assertion macros shared by the timer queue RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/mhtq_pkg.sv]
// Types and constants for the min-heap timer queue.
// No dependencies.
package mhtq_pkg;
    localparam int DEPTH = 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_ADJUST = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] user_id;
        logic [31:0] expire;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_id;
        logic [31:0] fired_expire;
        logic [5:0]  count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] exp;
        logic [15:0] uid;
        logic        live;
    } t_slot;

    // Memory port controls from the sequencer.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_slot         wdata;
        logic [AW-1:0] raddr;
    } t_mem_ctl;
endpackage

[rtl/core/mhtq_store.sv]
// Heap storage: one write port, one registered read port.
// Depends on mhtq_pkg.
module mhtq_store
    import mhtq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_ctl i_ctl,
    output t_slot    o_rdata
);
    t_slot r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        o_rdata <= r_mem[i_ctl.raddr];
    end
endmodule

[rtl/core/min_heap_timer_queue.sv]
// Min-heap timer queue top level: sequencer, shared compare unit, output register.
// Depends on mhtq_pkg, mhtq_store and assert_macros.svh.
//
// Usage: one input item (operation, user_id, expire, now) is taken on the
// i_in_valid/o_in_ready channel; results leave on o_out_valid/i_out_ready.
// Insert, cancel and adjust give one result with last set. A tick gives one
// fired result for each live expired entry, then a done result with last set.
// The block works on one item at a time and is not ready until the last
// result of that item has been taken. Every heap read goes through the one
// read port of the heap memory, at most one read per cycle with a registered
// read, so an insert reads one parent per level, a cancel scans all held
// entries one at a time, and each pop of a tick reads both children per level.
// Each result waits in the output register; while the receiver stalls, the
// sequencer holds once its next result is ready. Reset empties the heap at
// once (count to zero); heap memory contents are not cleared.
`include "assert_macros.svh"
module min_heap_timer_queue
    import mhtq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CSCAN = 14'b00000000000010,
        S_CCHK  = 14'b00000000000100,
        S_PUSH  = 14'b00000000001000,
        S_UPRD  = 14'b00000000010000,
        S_UPCMP = 14'b00000000100000,
        S_TTOP  = 14'b00000001000000,
        S_TCHK  = 14'b00000010000000,
        S_TLAST = 14'b00000100000000,
        S_DNRD  = 14'b00001000000000,
        S_DNCMP = 14'b00010000000000,
        S_DNRC  = 14'b00100000000000,
        S_EMIT  = 14'b01000000000000,
        S_DNMOV = 14'b10000000000000
    } t_state;

    t_state        r_state, n_state;
    t_in_item      r_item, n_item;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_hole, n_hole;
    logic [AW-1:0] r_idx, n_idx;
    t_slot         r_move, n_move;
    t_slot         r_lchild, n_lchild;
    logic          r_more, n_more;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_res, n_res;
    t_out_item     r_out, n_out;
    t_mem_ctl      mem_ctl;
    t_slot         rdata;

    // Shared comparator and index helpers.
    logic [31:0] cmp_a, cmp_b;
    logic        a_lt_b;
    logic [CW:0] left_w;
    assign a_lt_b = cmp_a < cmp_b;
    assign left_w = {1'b0, r_hole, 1'b1};

    mhtq_store u_store (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .o_rdata(rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_cnt    = r_cnt;
        n_hole   = r_hole;
        n_idx    = r_idx;
        n_move   = r_move;
        n_lchild = r_lchild;
        n_more   = r_more;
        n_ovalid = r_ovalid && !i_out_ready;
        n_res    = r_res;
        n_out    = r_out;
        mem_ctl  = '0;
        cmp_a    = '0;
        cmp_b    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_item = i_in_data;
                    n_idx  = '0;
                    mem_ctl.raddr = '0;
                    if (i_in_data.operation == OP_TICK) begin
                        n_state = S_TTOP;
                    end else if (i_in_data.operation == OP_INSERT) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_CSCAN;
                    end
                end
            end
            // Cancel (also the first part of adjust): read entry r_idx, then clear its live bit on a match.
            S_CSCAN: begin
                if ({1'b0, r_idx} >= r_cnt) begin
                    n_state = (r_item.operation == OP_ADJUST) ? S_PUSH : S_EMIT;
                    n_res = '{KIND_DONE, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                end else begin
                    mem_ctl.raddr = r_idx;
                    n_state = S_CCHK;
                end
            end
            S_CCHK: begin
                if (rdata.uid == r_item.user_id) begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = r_idx;
                    mem_ctl.wdata = '{rdata.exp, rdata.uid, 1'b0};
                end
                n_idx = r_idx + 1'b1;
                n_state = S_CSCAN;
                if ({1'b0, r_idx} == CW'(DEPTH - 1)) begin
                    n_state = (r_item.operation == OP_ADJUST) ? S_PUSH : S_EMIT;
                    n_res = '{KIND_DONE, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                end
            end
            // Insert: open a hole at the end, or reject when the heap is full.
            S_PUSH: begin
                n_move = '{r_item.expire, r_item.user_id, 1'b1};
                if (r_cnt >= CW'(DEPTH)) begin
                    n_res = '{KIND_REJECT, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_hole = r_cnt[AW-1:0];
                    n_cnt  = r_cnt + 1'b1;
                    n_state = S_UPRD;
                end
            end
            S_UPRD: begin
                if (r_hole == '0) begin
                    mem_ctl.we = 1'b1;
                    mem_ctl.waddr = r_hole;
                    mem_ctl.wdata = r_move;
                    n_res = '{KIND_DONE, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                    n_state = S_EMIT;
                end else begin
                    mem_ctl.raddr = (r_hole - 1'b1) >> 1;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                cmp_a = r_move.exp;
                cmp_b = rdata.exp;
                mem_ctl.we = 1'b1;
                mem_ctl.waddr = r_hole;
                if (a_lt_b) begin
                    mem_ctl.wdata = rdata;
                    n_hole = (r_hole - 1'b1) >> 1;
                    n_state = S_UPRD;
                end else begin
                    mem_ctl.wdata = r_move;
                    n_res = '{KIND_DONE, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                    n_state = S_EMIT;
                end
            end
            // Tick: check the root (read issued in the previous cycle).
            S_TTOP: begin
                if (r_cnt == '0) begin
                    n_res = '{KIND_DONE, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                    n_state = S_EMIT;
                end else begin
                    mem_ctl.raddr = '0;
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                cmp_a = r_item.now;
                cmp_b = rdata.exp;
                if (a_lt_b) begin
                    n_res = '{KIND_DONE, 16'd0, 32'd0, 6'(r_cnt), 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    n_more = rdata.live;
                    n_res = '{KIND_FIRED, rdata.uid, rdata.exp, 6'(r_cnt - 1'b1), 1'b0};
                    mem_ctl.raddr = AW'(r_cnt - 1'b1);
                    n_hole = '0;
                    n_state = S_TLAST;
                end
            end
            S_TLAST: begin
                n_move = rdata;
                n_state = (r_cnt == '0) ? S_EMIT : S_DNRD;
            end
            // Sift-down: read left child, then right child, then decide.
            S_DNRD: begin
                if (left_w >= (CW + 1)'(r_cnt)) begin
                    mem_ctl.we = 1'b1;
                    mem_ctl.waddr = r_hole;
                    mem_ctl.wdata = r_move;
                    n_state = S_EMIT;
                end else begin
                    mem_ctl.raddr = left_w[AW-1:0];
                    n_state = S_DNRC;
                end
            end
            S_DNRC: begin
                n_lchild = rdata;
                mem_ctl.raddr = AW'(left_w + 1'b1);
                n_state = S_DNCMP;
            end
            // Pick the smaller child; the right one only if strictly smaller.
            S_DNCMP: begin
                n_idx = left_w[AW-1:0];
                cmp_a = rdata.exp;
                cmp_b = r_lchild.exp;
                if (left_w + 1'b1 < (CW + 1)'(r_cnt) && a_lt_b) begin
                    n_lchild = rdata;
                    n_idx = AW'(left_w + 1'b1);
                end
                n_state = S_DNMOV;
            end
            // Move the chosen child up, or settle the moving entry.
            S_DNMOV: begin
                cmp_a = r_lchild.exp;
                cmp_b = r_move.exp;
                mem_ctl.we = 1'b1;
                mem_ctl.waddr = r_hole;
                if (a_lt_b) begin
                    mem_ctl.wdata = r_lchild;
                    n_hole = r_idx;
                    n_state = S_DNRD;
                end else begin
                    mem_ctl.wdata = r_move;
                    n_state = S_EMIT;
                end
            end
            // Hand a result over, or drop a dead pop and continue the tick.
            S_EMIT: begin
                mem_ctl.raddr = '0;
                if (r_res.kind == KIND_FIRED && !r_more) begin
                    n_state = S_TTOP;
                end else if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_out = r_res;
                    n_state = r_res.last ? S_IDLE : S_TTOP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_item   <= n_item;
        r_hole   <= n_hole;
        r_idx    <= n_idx;
        r_move   <= n_move;
        r_lchild <= n_lchild;
        r_more   <= n_more;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    `CHK_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH), "count above depth")
    `CHK_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE, "ready while busy")
    `CHK_NEXT(a_take_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `CHK_IMPL(a_kind_ok, i_clk, i_rst_n, o_out_valid, o_out_data.kind != 2'd3, "bad result kind")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")
endmodule

[tb/tb_min_heap_timer_queue.sv]
// Self-checking testbench for the min-heap timer queue.
// Depends on mhtq_pkg and the min_heap_timer_queue RTL.
`timescale 1ns / 100ps

// Predicts heap behavior and holds the expected result items in order.
class timer_heap_scoreboard;
    mhtq_pkg::t_slot   slots[mhtq_pkg::DEPTH];
    int unsigned       held;
    mhtq_pkg::t_out_item pending_results[$];
    int unsigned       errors;

    function new();
        held = 0;
        errors = 0;
    endfunction

    function void queue_result(logic [1:0] kind, logic [15:0] id, logic [31:0] ex,
                               logic last);
        mhtq_pkg::t_out_item r;
        r.kind = kind;
        r.fired_id = id;
        r.fired_expire = ex;
        r.count = held[5:0];
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function void settle_from_top();
        mhtq_pkg::t_slot moving;
        int unsigned hole, child;
        moving = slots[0];
        hole = 0;
        while (hole * 2 + 1 < held) begin
            child = hole * 2 + 1;
            if (child + 1 < held && slots[child + 1].exp < slots[child].exp)
                child++;
            if (slots[child].exp < moving.exp) begin
                slots[hole] = slots[child];
                hole = child;
            end else begin
                break;
            end
        end
        slots[hole] = moving;
    endfunction

    function bit insert_slot(logic [15:0] id, logic [31:0] ex);
        int unsigned hole, parent;
        if (held >= mhtq_pkg::DEPTH)
            return 0;
        hole = held;
        held++;
        while (hole > 0) begin
            parent = (hole - 1) / 2;
            if (slots[parent].exp <= ex)
                break;
            slots[hole] = slots[parent];
            hole = parent;
        end
        slots[hole].exp = ex;
        slots[hole].uid = id;
        slots[hole].live = 1'b1;
        return 1;
    endfunction

    // Works out the results of one accepted input item.
    function void note_input(mhtq_pkg::t_in_item it);
        mhtq_pkg::t_slot top;
        bit ok;
        if (it.operation == mhtq_pkg::OP_TICK) begin
            while (held > 0 && slots[0].exp <= it.now) begin
                top = slots[0];
                held--;
                if (held > 0) begin
                    slots[0] = slots[held];
                    settle_from_top();
                end
                if (top.live)
                    queue_result(mhtq_pkg::KIND_FIRED, top.uid, top.exp, 1'b0);
            end
            queue_result(mhtq_pkg::KIND_DONE, '0, '0, 1'b1);
            return;
        end
        if (it.operation == mhtq_pkg::OP_CANCEL || it.operation == mhtq_pkg::OP_ADJUST)
            for (int i = 0; i < held; i++)
                if (slots[i].uid == it.user_id)
                    slots[i].live = 1'b0;
        if (it.operation == mhtq_pkg::OP_CANCEL) begin
            queue_result(mhtq_pkg::KIND_DONE, '0, '0, 1'b1);
        end else begin
            ok = insert_slot(it.user_id, it.expire);
            queue_result(ok ? mhtq_pkg::KIND_DONE : mhtq_pkg::KIND_REJECT, '0, '0, 1'b1);
        end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(mhtq_pkg::t_out_item got);
        mhtq_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.fired_id !== want.fired_id)
            $display("%0t: fired_id expected %h actual %h", $time, want.fired_id,
                     got.fired_id);
        if (got.fired_expire !== want.fired_expire)
            $display("%0t: fired_expire expected %h actual %h", $time,
                     want.fired_expire, got.fired_expire);
        if (got.count !== want.count)
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        if (got.last !== want.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got !== want)
            errors++;
    endfunction
endclass

module tb_min_heap_timer_queue;
    import mhtq_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    timer_heap_scoreboard board;
    bit  quiet_tail;
    bit  hold_receiver;
    int  idle_cycles;

    min_heap_timer_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Offers one item, with an optional idle burst first.
    task automatic send_item(logic [1:0] op, logic [15:0] id, logic [31:0] ex,
                             logic [31:0] now_s);
        t_in_item it;
        int gap;
        it.operation = op;
        it.user_id = id;
        it.expire = ex;
        it.now = now_s;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(it);
    endtask

    // Random id drawn mostly from a small pool so cancels hit held timers.
    function automatic logic [15:0] pick_id();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    endfunction

    // Result sink with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                board.check_result(o_out_data);
            if (hold_receiver)
                i_out_ready <= 1'b0;
            else if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                idle_cycles <= $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        hold_receiver = 1'b0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_receiver = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_receiver = 1'b0;
    end

    // Watchdog on cycles with no accepted item and no accepted result.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else if (!hold_receiver)
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int waited;
        logic [31:0] clock_now;
        board = new();
        quiet_tail = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, extremes, equal expiries, cancel, adjust.
        send_item(OP_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_INSERT, 16'h0000, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 16'h0001, 32'd5, 32'h0);
        send_item(OP_INSERT, 16'h0002, 32'd5, 32'h0);
        send_item(OP_INSERT, 16'h0003, 32'd5, 32'h0);
        send_item(OP_CANCEL, 16'h0002, 32'h0, 32'h0);
        send_item(OP_CANCEL, 16'h1234, 32'h0, 32'h0);
        send_item(OP_ADJUST, 16'h0001, 32'd3, 32'h0);
        send_item(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'd4);
        send_item(OP_TICK, 16'h0, 32'h0, 32'd5);
        // Fill to the limit, then overflow by insert and by adjust.
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(OP_INSERT, 16'(i % 5), 32'($urandom_range(10, 20)), 32'h0);
        send_item(OP_ADJUST, 16'h0003, 32'd7, 32'h0);
        send_item(OP_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);

        // Random: mostly inserts and ticks along an advancing clock.
        clock_now = 32'd100;
        for (int n = 0; n < 200; n++) begin
            int sel;
            if (n > 170)
                quiet_tail = 1'b1;
            sel = $urandom_range(0, 9);
            if (n % 40 == 39)
                clock_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            if (sel < 4)
                send_item(OP_INSERT, pick_id(),
                          ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                      : clock_now + $urandom_range(0, 60),
                          32'($urandom));
            else if (sel < 5)
                send_item(OP_CANCEL, pick_id(), 32'($urandom), 32'($urandom));
            else if (sel < 7)
                send_item(OP_ADJUST, pick_id(), clock_now + $urandom_range(0, 60),
                          32'($urandom));
            else begin
                clock_now = clock_now + $urandom_range(0, 30);
                send_item(OP_TICK, 16'($urandom), 32'($urandom),
                          ($urandom_range(0, 15) == 0) ? 32'($urandom) : clock_now);
            end
        end
        i_in_valid <= 1'b0;

        // Drain the remaining expected results.
        waited = 0;
        while (board.pending_results.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
